FILE: rtl/uvs_pkg.sv
// ----------------------------------------------------------------------------
// uvs_pkg: shared types, constants and helpers of the UV sphere tessellator
// Field widths, sine coefficients, register indexes and the stage payloads.
// ----------------------------------------------------------------------------
package uvs_pkg;

   localparam int COUNT_W     = 7;
   localparam int RADIUS_W    = 16;
   localparam int POS_W       = 17;
   localparam int NORM_W      = 16;
   localparam int TEX_W       = 16;
   localparam int INDEX_W     = 13;
   localparam int CELL_W      = 15;
   localparam int PHASE_W     = 16;
   localparam int QUOT_W      = 17;
   localparam int NUM_W       = COUNT_W + QUOT_W;
   localparam int COEF_W      = 31;
   localparam int CSR_INDEX_W = 2;
   localparam int CSR_DATA_W  = 16;
   localparam int DIV_LANES   = 3;
   localparam int TRIG_LANES  = 4;

   // divider lanes
   localparam int LANE_THETA = 0;
   localparam int LANE_TEX_S = 1;
   localparam int LANE_PHI   = 2;

   // sine lanes
   localparam int TRIG_SIN_THETA = 0;
   localparam int TRIG_COS_THETA = 1;
   localparam int TRIG_SIN_PHI   = 2;
   localparam int TRIG_COS_PHI   = 3;

   localparam logic MODE_VERTEX = 1'b0;
   localparam logic MODE_CELL   = 1'b1;

   localparam logic [PHASE_W-1:0] QUARTER_TURN = 16'd16384;
   localparam logic [15:0]        ONE_Q14      = 16'd16384;

   // odd Taylor coefficients of sin(pi/2 * z), Q30
   localparam logic [COEF_W-1:0] A1 = 31'd1686629713;
   localparam logic [COEF_W-1:0] A3 = 31'd693598668;
   localparam logic [COEF_W-1:0] A5 = 31'd85569306;
   localparam logic [COEF_W-1:0] A7 = 31'd5026995;
   localparam logic [COEF_W-1:0] A9 = 31'd172272;

   typedef enum logic [CSR_INDEX_W-1:0] {
      CSR_SLICE_COUNT   = 2'd0,
      CSR_STACK_COUNT   = 2'd1,
      CSR_SPHERE_RADIUS = 2'd2
   } csr_index_type;

   typedef struct packed {
      logic               mode;
      logic [COUNT_W-1:0] slice;
      logic [COUNT_W-1:0] stack;
   } item_type;

   typedef struct packed {
      item_type         item;
      logic [TEX_W-1:0] tex_s;
      logic [TEX_W-1:0] tex_t;
   } vtx_tag_type;

   typedef struct packed {
      logic signed [NORM_W-1:0] sin_theta;
      logic signed [NORM_W-1:0] cos_theta;
      logic signed [NORM_W-1:0] sin_phi;
      logic signed [NORM_W-1:0] cos_phi;
   } trig_type;

   // one Horner step: c - (r * z2) / 2^30, truncating
   function automatic logic [COEF_W-1:0] horner(input logic [COEF_W-1:0] c,
                                                input logic [COEF_W-1:0] r,
                                                input logic [COEF_W-1:0] z2);
      logic [2*COEF_W-1:0] prod;
      prod = r * z2;
      return c - prod[2*COEF_W-2:30];
   endfunction

   // v / 2^14 rounded, ties away from zero
   function automatic logic signed [19:0] round_q14(input logic signed [33:0] v);
      logic [33:0]        mag;
      logic [33:0]        rnd;
      logic signed [19:0] res;
      mag = v[33] ? 34'(-v) : 34'(v);
      rnd = (mag + 34'd8192) >> 14;
      res = signed'(rnd[19:0]);
      return v[33] ? -res : res;
   endfunction

endpackage

FILE: rtl/uvs_phase_div.sv
// ----------------------------------------------------------------------------
// uvs_phase_div: pipelined restoring divider for grid phases
// Forms the theta phase, tex_s and the phi phase (= tex_t) one quotient bit
// per stage; the item payload travels alongside.
// ----------------------------------------------------------------------------
module uvs_phase_div (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          in_valid,
   input  uvs_pkg::item_type             in_item,
   input  logic [uvs_pkg::COUNT_W-1:0]   slice_count,
   input  logic [uvs_pkg::COUNT_W-1:0]   stack_count,
   output logic                          out_valid,
   output uvs_pkg::item_type             out_item,
   output logic [uvs_pkg::QUOT_W-1:0]    out_theta,
   output logic [uvs_pkg::TEX_W-1:0]     out_tex_s,
   output logic [uvs_pkg::TEX_W-1:0]     out_phi
);

   localparam int QW = uvs_pkg::QUOT_W;
   localparam int CW = uvs_pkg::COUNT_W;
   localparam int NL = uvs_pkg::DIV_LANES;

   logic [CW-1:0]         rem_ff  [0:QW][NL];
   logic [CW-1:0]         rem_in  [0:QW][NL];
   logic [QW-1:0]         low_ff  [0:QW][NL];
   logic [QW-1:0]         low_in  [0:QW][NL];
   logic [QW-1:0]         quo_ff  [0:QW][NL];
   logic [QW-1:0]         quo_in  [0:QW][NL];
   logic                  valid_ff [0:QW];
   logic                  valid_in [0:QW];
   uvs_pkg::item_type     item_ff [0:QW];
   uvs_pkg::item_type     item_in [0:QW];
   logic [uvs_pkg::NUM_W-1:0] num    [NL];
   logic [CW-1:0]             divisor [NL];

   // numerators with round-half bias: i * 2^16, i * 2^15 and j * 2^15
   always_comb begin
      num[uvs_pkg::LANE_THETA] = {1'b0, in_item.slice, 16'd0} + uvs_pkg::NUM_W'(slice_count >> 1);
      num[uvs_pkg::LANE_TEX_S] = {2'b00, in_item.slice, 15'd0} + uvs_pkg::NUM_W'(slice_count >> 1);
      num[uvs_pkg::LANE_PHI]   = {2'b00, in_item.stack, 15'd0} + uvs_pkg::NUM_W'(stack_count >> 1);
      divisor[uvs_pkg::LANE_THETA] = slice_count;
      divisor[uvs_pkg::LANE_TEX_S] = slice_count;
      divisor[uvs_pkg::LANE_PHI]   = stack_count;
   end

   // load stage zero, then one restoring step per stage
   always_comb begin
      logic [CW:0] trial;
      logic        ge;
      valid_in[0] = in_valid;
      item_in[0]  = in_item;
      for (int l = 0; l < NL; l++) begin
         rem_in[0][l] = num[l][uvs_pkg::NUM_W-1:QW];
         low_in[0][l] = num[l][QW-1:0];
         quo_in[0][l] = '0;
      end
      for (int k = 1; k <= QW; k++) begin
         valid_in[k] = valid_ff[k-1];
         item_in[k]  = item_ff[k-1];
         for (int l = 0; l < NL; l++) begin
            trial = {rem_ff[k-1][l], low_ff[k-1][l][QW-1]};
            ge    = (trial >= {1'b0, divisor[l]});
            rem_in[k][l] = ge ? CW'(trial - {1'b0, divisor[l]}) : CW'(trial);
            low_in[k][l] = {low_ff[k-1][l][QW-2:0], 1'b0};
            quo_in[k][l] = {quo_ff[k-1][l][QW-2:0], ge};
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int k = 0; k <= QW; k++) valid_ff[k] <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rem_ff  <= rem_in;
      low_ff  <= low_in;
      quo_ff  <= quo_in;
      item_ff <= item_in;
   end

   assign out_valid = valid_ff[QW];
   assign out_item  = item_ff[QW];
   assign out_theta = quo_ff[QW][uvs_pkg::LANE_THETA];
   assign out_tex_s = quo_ff[QW][uvs_pkg::LANE_TEX_S][uvs_pkg::TEX_W-1:0];
   assign out_phi   = quo_ff[QW][uvs_pkg::LANE_PHI][uvs_pkg::TEX_W-1:0];

endmodule

FILE: rtl/uvs_sine.sv
// ----------------------------------------------------------------------------
// uvs_sine: four-lane pipelined sine of a 16-bit phase
// Quadrant fold, then a degree-9 odd polynomial by Horner, one product a stage.
// ----------------------------------------------------------------------------
module uvs_sine (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        in_valid,
   input  uvs_pkg::vtx_tag_type        in_tag,
   input  logic [uvs_pkg::PHASE_W-1:0] in_phase [uvs_pkg::TRIG_LANES],
   output logic                        out_valid,
   output uvs_pkg::vtx_tag_type        out_tag,
   output uvs_pkg::trig_type           out_trig
);

   localparam int NL = uvs_pkg::TRIG_LANES;
   localparam int KW = uvs_pkg::COEF_W;
   localparam int ST = 6;

   logic                 valid_ff [1:ST];
   uvs_pkg::vtx_tag_type tag_ff   [1:ST];
   logic [14:0]          x_ff     [1:ST-1][NL];
   logic                 neg_ff   [1:ST-1][NL];
   logic [KW-1:0]        z2_ff    [1:ST-1][NL];
   logic [KW-1:0]        r_ff     [2:ST-1][NL];
   logic signed [uvs_pkg::NORM_W-1:0] val_ff [NL];
   logic [14:0]          x_in     [NL];
   logic [29:0]          xsq      [NL];
   logic signed [uvs_pkg::NORM_W-1:0] val_in [NL];

   // fold phase into first quadrant
   always_comb begin
      for (int l = 0; l < NL; l++) begin
         x_in[l] = in_phase[l][14] ? 15'd16384 - {1'b0, in_phase[l][13:0]}
                                   : {1'b0, in_phase[l][13:0]};
         xsq[l]  = x_in[l] * x_in[l];
      end
   end

   // final product, round to Q1.14, cap and apply sign
   always_comb begin
      logic [45:0] prod;
      logic [31:0] acc;
      logic [15:0] mag;
      for (int l = 0; l < NL; l++) begin
         prod = r_ff[ST-1][l] * x_ff[ST-1][l];
         acc  = prod[45:14] + 32'd32768;
         mag  = acc[31:16];
         if (mag > uvs_pkg::ONE_Q14) mag = uvs_pkg::ONE_Q14;
         val_in[l] = neg_ff[ST-1][l] ? -signed'(mag) : signed'(mag);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int k = 1; k <= ST; k++) valid_ff[k] <= 1'b0;
      end else begin
         valid_ff[1] <= in_valid;
         for (int k = 2; k <= ST; k++) valid_ff[k] <= valid_ff[k-1];
      end
   end

   // advance the polynomial one term per stage
   always_ff @(posedge clock) begin
      tag_ff[1] <= in_tag;
      for (int k = 2; k <= ST; k++) tag_ff[k] <= tag_ff[k-1];
      for (int l = 0; l < NL; l++) begin
         x_ff[1][l]   <= x_in[l];
         neg_ff[1][l] <= in_phase[l][15];
         z2_ff[1][l]  <= KW'({xsq[l], 2'b00});
         for (int k = 2; k <= ST-1; k++) begin
            x_ff[k][l]   <= x_ff[k-1][l];
            neg_ff[k][l] <= neg_ff[k-1][l];
            z2_ff[k][l]  <= z2_ff[k-1][l];
         end
         r_ff[2][l] <= uvs_pkg::horner(uvs_pkg::A7, uvs_pkg::A9, z2_ff[1][l]);
         r_ff[3][l] <= uvs_pkg::horner(uvs_pkg::A5, r_ff[2][l], z2_ff[2][l]);
         r_ff[4][l] <= uvs_pkg::horner(uvs_pkg::A3, r_ff[3][l], z2_ff[3][l]);
         r_ff[5][l] <= uvs_pkg::horner(uvs_pkg::A1, r_ff[4][l], z2_ff[4][l]);
         val_ff[l]  <= val_in[l];
      end
   end

   assign out_valid          = valid_ff[ST];
   assign out_tag            = tag_ff[ST];
   assign out_trig.sin_theta = val_ff[uvs_pkg::TRIG_SIN_THETA];
   assign out_trig.cos_theta = val_ff[uvs_pkg::TRIG_COS_THETA];
   assign out_trig.sin_phi   = val_ff[uvs_pkg::TRIG_SIN_PHI];
   assign out_trig.cos_phi   = val_ff[uvs_pkg::TRIG_COS_PHI];

endmodule

FILE: rtl/uvs_mesh_out.sv
// ----------------------------------------------------------------------------
// uvs_mesh_out: normals, positions, cell triangles and result sequencing
// Three register stages; a cell with two triangles sends the second one
// in the cycle after the first.
// ----------------------------------------------------------------------------
module uvs_mesh_out (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                in_valid,
   input  uvs_pkg::vtx_tag_type                in_tag,
   input  uvs_pkg::trig_type                   in_trig,
   input  logic [uvs_pkg::COUNT_W-1:0]         stack_count,
   input  logic [uvs_pkg::RADIUS_W-1:0]        sphere_radius,
   output logic                                rsp_strobe,
   output logic signed [uvs_pkg::POS_W-1:0]    rsp_pos_x,
   output logic signed [uvs_pkg::POS_W-1:0]    rsp_pos_y,
   output logic signed [uvs_pkg::POS_W-1:0]    rsp_pos_z,
   output logic signed [uvs_pkg::NORM_W-1:0]   rsp_norm_x,
   output logic signed [uvs_pkg::NORM_W-1:0]   rsp_norm_y,
   output logic signed [uvs_pkg::NORM_W-1:0]   rsp_norm_z,
   output logic [uvs_pkg::TEX_W-1:0]           rsp_tex_s,
   output logic [uvs_pkg::TEX_W-1:0]           rsp_tex_t,
   output logic [uvs_pkg::INDEX_W-1:0]         rsp_index_a,
   output logic [uvs_pkg::INDEX_W-1:0]         rsp_index_b,
   output logic [uvs_pkg::INDEX_W-1:0]         rsp_index_c,
   output logic                                rsp_last
);

   localparam int CLW = uvs_pkg::CELL_W;
   localparam int NW  = uvs_pkg::NORM_W;
   localparam int PW  = uvs_pkg::POS_W;

   // stage 1: raw products and row base
   logic                 m1_valid_ff;
   uvs_pkg::vtx_tag_type m1_tag_ff;
   logic signed [31:0]   m1_nxp_ff, m1_nyp_ff;
   logic signed [NW-1:0] m1_nz_ff;
   logic [CLW-1:0]       m1_here_ff;

   // stage 2: rounded normals and triangles
   logic                 m2_valid_ff;
   uvs_pkg::vtx_tag_type m2_tag_ff;
   logic signed [NW-1:0] m2_nx_ff, m2_ny_ff, m2_nz_ff;
   logic [CLW-1:0]       m2_a1_ff, m2_b1_ff, m2_c1_ff, m2_a2_ff, m2_b2_ff, m2_c2_ff;
   logic                 m2_two_ff;
   logic [CLW-1:0]       a1_in, b1_in, c1_in, a2_in, b2_in, c2_in;
   logic                 two_in;
   logic signed [19:0]   nx_in, ny_in;

   // output stage and pending second triangle
   logic                 strobe_ff, strobe_in;
   logic signed [PW-1:0] px_ff, py_ff, pz_ff, px_in, py_in, pz_in;
   logic signed [NW-1:0] nx_ff, ny_ff, nz_ff, onx_in, ony_in, onz_in;
   logic [uvs_pkg::TEX_W-1:0]   ts_ff, tt_ff, ts_in, tt_in;
   logic [uvs_pkg::INDEX_W-1:0] ia_ff, ib_ff, ic_ff, ia_in, ib_in, ic_in;
   logic                 last_ff, last_in;
   logic                 sec_ff, sec_in;
   logic [CLW-1:0]       sa_ff, sb_ff, sc_ff;
   logic signed [19:0]   rx, ry, rz;
   logic signed [PW-1:0] rad_s;

   // row base, triangle selection and rounding of the x and y normals
   always_comb begin
      logic [CLW-1:0]           nxt_row;
      logic [CLW-1:0]           jj;
      logic [uvs_pkg::COUNT_W-1:0] top_stack;
      nxt_row   = m1_here_ff + CLW'(stack_count) + CLW'(1);
      jj        = CLW'(m1_tag_ff.item.stack);
      top_stack = uvs_pkg::COUNT_W'(stack_count - 1'b1);
      two_in    = 1'b0;
      a2_in     = nxt_row + jj;
      b2_in     = m1_here_ff + jj;
      c2_in     = nxt_row + jj + CLW'(1);
      if (m1_tag_ff.item.stack == '0) begin
         a1_in = m1_here_ff;
         b1_in = m1_here_ff + CLW'(1);
         c1_in = nxt_row + CLW'(1);
      end else if (m1_tag_ff.item.stack == top_stack) begin
         a1_in = m1_here_ff + jj;
         b1_in = m1_here_ff + jj + CLW'(1);
         c1_in = nxt_row + jj;
      end else begin
         a1_in  = m1_here_ff + jj;
         b1_in  = m1_here_ff + jj + CLW'(1);
         c1_in  = nxt_row + jj + CLW'(1);
         two_in = 1'b1;
      end
      nx_in = uvs_pkg::round_q14(34'(m1_nxp_ff));
      ny_in = uvs_pkg::round_q14(34'(m1_nyp_ff));
   end

   // scale normals by radius and build the result
   always_comb begin
      rad_s = signed'({1'b0, sphere_radius});
      rx = uvs_pkg::round_q14(34'(rad_s * m2_nx_ff));
      ry = uvs_pkg::round_q14(34'(rad_s * m2_ny_ff));
      rz = uvs_pkg::round_q14(34'(rad_s * m2_nz_ff));
      strobe_in = 1'b0;
      sec_in    = 1'b0;
      px_in = '0; py_in = '0; pz_in = '0;
      onx_in = '0; ony_in = '0; onz_in = '0;
      ts_in = '0; tt_in = '0;
      ia_in = '0; ib_in = '0; ic_in = '0;
      last_in = 1'b1;
      if (m2_valid_ff) begin
         strobe_in = 1'b1;
         if (m2_tag_ff.item.mode == uvs_pkg::MODE_VERTEX) begin
            px_in  = rx[PW-1:0];
            py_in  = ry[PW-1:0];
            pz_in  = rz[PW-1:0];
            onx_in = m2_nx_ff;
            ony_in = m2_ny_ff;
            onz_in = m2_nz_ff;
            ts_in  = m2_tag_ff.tex_s;
            tt_in  = m2_tag_ff.tex_t;
         end else begin
            ia_in   = m2_a1_ff[uvs_pkg::INDEX_W-1:0];
            ib_in   = m2_b1_ff[uvs_pkg::INDEX_W-1:0];
            ic_in   = m2_c1_ff[uvs_pkg::INDEX_W-1:0];
            last_in = !m2_two_ff;
            sec_in  = m2_two_ff;
         end
      end else if (sec_ff) begin
         strobe_in = 1'b1;
         ia_in = sa_ff[uvs_pkg::INDEX_W-1:0];
         ib_in = sb_ff[uvs_pkg::INDEX_W-1:0];
         ic_in = sc_ff[uvs_pkg::INDEX_W-1:0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         m1_valid_ff <= 1'b0;
         m2_valid_ff <= 1'b0;
         strobe_ff   <= 1'b0;
         sec_ff      <= 1'b0;
      end else begin
         m1_valid_ff <= in_valid;
         m2_valid_ff <= m1_valid_ff;
         strobe_ff   <= strobe_in;
         sec_ff      <= sec_in;
      end
   end

   always_ff @(posedge clock) begin
      m1_tag_ff  <= in_tag;
      m1_nxp_ff  <= in_trig.sin_phi * in_trig.cos_theta;
      m1_nyp_ff  <= in_trig.sin_phi * in_trig.sin_theta;
      m1_nz_ff   <= in_trig.cos_phi;
      m1_here_ff <= CLW'(in_tag.item.slice) * (CLW'(stack_count) + CLW'(1));
      m2_tag_ff  <= m1_tag_ff;
      m2_nx_ff   <= nx_in[NW-1:0];
      m2_ny_ff   <= ny_in[NW-1:0];
      m2_nz_ff   <= m1_nz_ff;
      m2_a1_ff   <= a1_in;
      m2_b1_ff   <= b1_in;
      m2_c1_ff   <= c1_in;
      m2_a2_ff   <= a2_in;
      m2_b2_ff   <= b2_in;
      m2_c2_ff   <= c2_in;
      m2_two_ff  <= two_in;
      // hold the second triangle for the next cycle
      if (m2_valid_ff) begin
         sa_ff <= m2_a2_ff;
         sb_ff <= m2_b2_ff;
         sc_ff <= m2_c2_ff;
      end
      px_ff <= px_in; py_ff <= py_in; pz_ff <= pz_in;
      nx_ff <= onx_in; ny_ff <= ony_in; nz_ff <= onz_in;
      ts_ff <= ts_in; tt_ff <= tt_in;
      ia_ff <= ia_in; ib_ff <= ib_in; ic_ff <= ic_in;
      last_ff <= last_in;
   end

   assign rsp_strobe  = strobe_ff;
   assign rsp_pos_x   = px_ff;
   assign rsp_pos_y   = py_ff;
   assign rsp_pos_z   = pz_ff;
   assign rsp_norm_x  = nx_ff;
   assign rsp_norm_y  = ny_ff;
   assign rsp_norm_z  = nz_ff;
   assign rsp_tex_s   = ts_ff;
   assign rsp_tex_t   = tt_ff;
   assign rsp_index_a = ia_ff;
   assign rsp_index_b = ib_ff;
   assign rsp_index_c = ic_ff;
   assign rsp_last    = last_ff;

endmodule

FILE: rtl/uv_sphere_mesh_generator.sv
// ----------------------------------------------------------------------------
// uv_sphere_mesh_generator: UV sphere vertex and triangle generator
// Gives one vertex of a grid point, or the triangles of one grid cell.
// ----------------------------------------------------------------------------
// Usage:
//   A request transfers on a rising edge with start high and busy low. It
//   carries a mode (vertex or cell) and a slice and stack index.
//   A vertex request gives one result; a cell request gives one triangle on
//   the first and last stacks and two on the others. rsp_strobe marks each
//   result for one cycle and rsp_last marks the final one of a request.
//   A request passes the 18-stage phase divider (a load stage, loaded at
//   the accepting edge, and 17 quotient steps), the 6-stage sine pipeline
//   and 3 output stages; a second triangle comes in the cycle after the
//   first. Vertex requests may follow each other in every cycle; busy rises
//   for one cycle after a cell request and holds off new requests while high.
//   The receiver cannot stall: results are shown once and never held.
//   Registers are written through csr_valid/csr_ready (always ready) with
//   csr_index and csr_data; the user must write them only while no request
//   is in flight, and the block itself has no check for this.
//   Reset clears the pipeline and loads 10 slices, 10 stacks, radius 1.0.
// ----------------------------------------------------------------------------
module uv_sphere_mesh_generator #(
   parameter int MAX_SLICES = 64,
   parameter int MAX_STACKS = 64
) (
   input  logic                                    clock,
   input  logic                                    reset,
   input  logic                                    start,
   output logic                                    busy,
   input  logic                                    req_mode,
   input  logic [uvs_pkg::COUNT_W-1:0]             req_slice_index,
   input  logic [uvs_pkg::COUNT_W-1:0]             req_stack_index,
   input  logic                                    csr_valid,
   output logic                                    csr_ready,
   input  logic [uvs_pkg::CSR_INDEX_W-1:0]         csr_index,
   input  logic [uvs_pkg::CSR_DATA_W-1:0]          csr_data,
   output logic                                    rsp_strobe,
   output logic signed [uvs_pkg::POS_W-1:0]        rsp_pos_x,
   output logic signed [uvs_pkg::POS_W-1:0]        rsp_pos_y,
   output logic signed [uvs_pkg::POS_W-1:0]        rsp_pos_z,
   output logic signed [uvs_pkg::NORM_W-1:0]       rsp_norm_x,
   output logic signed [uvs_pkg::NORM_W-1:0]       rsp_norm_y,
   output logic signed [uvs_pkg::NORM_W-1:0]       rsp_norm_z,
   output logic [uvs_pkg::TEX_W-1:0]               rsp_tex_s,
   output logic [uvs_pkg::TEX_W-1:0]               rsp_tex_t,
   output logic [uvs_pkg::INDEX_W-1:0]             rsp_index_a,
   output logic [uvs_pkg::INDEX_W-1:0]             rsp_index_b,
   output logic [uvs_pkg::INDEX_W-1:0]             rsp_index_c,
   output logic                                    rsp_last
);

   localparam int CW = uvs_pkg::COUNT_W;
   localparam logic [CW-1:0] SLICE_RESET = (MAX_SLICES < 10) ? CW'(MAX_SLICES) : 7'd10;
   localparam logic [CW-1:0] STACK_RESET = (MAX_STACKS < 10) ? CW'(MAX_STACKS) : 7'd10;

   logic [CW-1:0]                 slices_ff, slices_in;
   logic [CW-1:0]                 stacks_ff, stacks_in;
   logic [uvs_pkg::RADIUS_W-1:0]  radius_ff, radius_in;
   logic                          busy_ff, busy_in;
   logic                          accept;
   uvs_pkg::item_type             item;
   logic [CW-1:0]                 slice_lim, stack_lim;

   logic                          div_valid;
   uvs_pkg::item_type             div_item;
   logic [uvs_pkg::QUOT_W-1:0]    div_theta;
   logic [uvs_pkg::TEX_W-1:0]     div_tex_s, div_phi;
   uvs_pkg::vtx_tag_type          sin_tag_in, sin_tag;
   logic [uvs_pkg::PHASE_W-1:0]   phase [uvs_pkg::TRIG_LANES];
   logic                          sin_valid;
   uvs_pkg::trig_type             trig;

   assign accept    = start && !busy_ff;
   assign busy      = busy_ff;
   assign csr_ready = 1'b1;

   // clamp counts on write, keep only the usable values
   always_comb begin
      logic [CW-1:0] val;
      val       = csr_data[CW-1:0];
      slices_in = slices_ff;
      stacks_in = stacks_ff;
      radius_in = radius_ff;
      if (csr_valid) begin
         case (csr_index)
            uvs_pkg::CSR_SLICE_COUNT: begin
               if (val < 7'd1) slices_in = 7'd1;
               else if (int'(val) > MAX_SLICES) slices_in = CW'(MAX_SLICES);
               else slices_in = val;
            end
            uvs_pkg::CSR_STACK_COUNT: begin
               if (val < 7'd2) stacks_in = 7'd2;
               else if (int'(val) > MAX_STACKS) stacks_in = CW'(MAX_STACKS);
               else stacks_in = val;
            end
            uvs_pkg::CSR_SPHERE_RADIUS: radius_in = csr_data;
            default: ;
         endcase
      end
   end

   // saturate the grid position to the mode's range
   always_comb begin
      slice_lim = (req_mode == uvs_pkg::MODE_CELL) ? CW'(slices_ff - 1'b1) : slices_ff;
      stack_lim = (req_mode == uvs_pkg::MODE_CELL) ? CW'(stacks_ff - 1'b1) : stacks_ff;
      item.mode  = req_mode;
      item.slice = (req_slice_index > slice_lim) ? slice_lim : req_slice_index;
      item.stack = (req_stack_index > stack_lim) ? stack_lim : req_stack_index;
      busy_in    = accept && (req_mode == uvs_pkg::MODE_CELL);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         slices_ff <= SLICE_RESET;
         stacks_ff <= STACK_RESET;
         radius_ff <= 16'd256;
         busy_ff   <= 1'b0;
      end else begin
         slices_ff <= slices_in;
         stacks_ff <= stacks_in;
         radius_ff <= radius_in;
         busy_ff   <= busy_in;
      end
   end

   uvs_phase_div u_div (
      .clock       (clock),
      .reset       (reset),
      .in_valid    (accept),
      .in_item     (item),
      .slice_count (slices_ff),
      .stack_count (stacks_ff),
      .out_valid   (div_valid),
      .out_item    (div_item),
      .out_theta   (div_theta),
      .out_tex_s   (div_tex_s),
      .out_phi     (div_phi)
   );

   // cosine is the sine a quarter turn ahead
   always_comb begin
      phase[uvs_pkg::TRIG_SIN_THETA] = div_theta[uvs_pkg::PHASE_W-1:0];
      phase[uvs_pkg::TRIG_COS_THETA] = div_theta[uvs_pkg::PHASE_W-1:0] + uvs_pkg::QUARTER_TURN;
      phase[uvs_pkg::TRIG_SIN_PHI]   = div_phi;
      phase[uvs_pkg::TRIG_COS_PHI]   = div_phi + uvs_pkg::QUARTER_TURN;
      sin_tag_in.item  = div_item;
      sin_tag_in.tex_s = div_tex_s;
      sin_tag_in.tex_t = div_phi;
   end

   uvs_sine u_sine (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (div_valid),
      .in_tag    (sin_tag_in),
      .in_phase  (phase),
      .out_valid (sin_valid),
      .out_tag   (sin_tag),
      .out_trig  (trig)
   );

   uvs_mesh_out u_out (
      .clock         (clock),
      .reset         (reset),
      .in_valid      (sin_valid),
      .in_tag        (sin_tag),
      .in_trig       (trig),
      .stack_count   (stacks_ff),
      .sphere_radius (radius_ff),
      .rsp_strobe    (rsp_strobe),
      .rsp_pos_x     (rsp_pos_x),
      .rsp_pos_y     (rsp_pos_y),
      .rsp_pos_z     (rsp_pos_z),
      .rsp_norm_x    (rsp_norm_x),
      .rsp_norm_y    (rsp_norm_y),
      .rsp_norm_z    (rsp_norm_z),
      .rsp_tex_s     (rsp_tex_s),
      .rsp_tex_t     (rsp_tex_t),
      .rsp_index_a   (rsp_index_a),
      .rsp_index_b   (rsp_index_b),
      .rsp_index_c   (rsp_index_c),
      .rsp_last      (rsp_last)
   );

   // busy only follows a cell transfer
   a_busy_cause: assert property (@(posedge clock) disable iff (reset)
      busy |-> $past(start && !busy && req_mode == uvs_pkg::MODE_CELL))
      else $error("busy without a preceding cell transfer");

   // busy is never high in consecutive cycles
   a_busy_short: assert property (@(posedge clock) disable iff (reset)
      busy |=> !busy)
      else $error("busy held for two cycles");

   // a non-final result is followed by the final one
   a_second_tri: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe && !rsp_last |=> rsp_strobe && rsp_last)
      else $error("second triangle missing");

endmodule
